FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");

`endif

FILE: hw/rtl/trie_pkg.sv
package trie_pkg;

   localparam int LENGTH_BITS = 16;
   localparam int LEN_BYTES   = (LENGTH_BITS + 7) / 8;
   localparam int LB_W        = 4;
   localparam int POS_W       = 17;
   localparam int ACC_W       = 33;

   typedef enum logic [5:0] {
      PH_OUTER_HDR  = 6'b000001,
      PH_OUTER_LEN  = 6'b000010,
      PH_FIELD_HDR  = 6'b000100,
      PH_FIELD_LEN  = 6'b001000,
      PH_FIELD_BODY = 6'b010000,
      PH_DONE       = 6'b100000
   } phase_type;

   localparam logic [1:0] SHAPE_EMPTY  = 2'd0;
   localparam logic [1:0] SHAPE_INLINE = 2'd1;
   localparam logic [1:0] SHAPE_HASH   = 2'd2;
   localparam logic [1:0] SHAPE_OTHER  = 2'd3;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_LEAF   = 2'd1;
   localparam logic [1:0] KIND_EXT    = 2'd2;
   localparam logic [1:0] KIND_BRANCH = 2'd3;

   localparam logic [4:0] BRANCH_FIELDS = 5'd17;

   typedef struct packed {
      logic       record_type;
      logic [4:0] field_index;
      logic       field_is_list;
      logic [15:0] field_start;
      logic [1:0] header_size;
      logic [15:0] content_size;
      logic [1:0] child_shape;
      logic [1:0] node_kind;
      logic [6:0] path_nibbles;
      logic       path_odd;
      logic       node_valid;
      logic       last_result;
   } rec_type;

   // Result items caused by one byte: up to a descriptor and a verdict.
   typedef struct packed {
      logic    desc_valid;
      logic    verd_valid;
      rec_type desc;
      rec_type verd;
   } step_type;

endpackage

FILE: hw/rtl/trie_parse.sv
module trie_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          data_byte,
   input  logic                end_of_node,
   output trie_pkg::step_type  step
);

   localparam logic [trie_pkg::ACC_W-1:0] LEN_LIMIT_HI =
      trie_pkg::ACC_W'((64'd1 << trie_pkg::LENGTH_BITS) - 1) >> 8;

   trie_pkg::phase_type phase_ff, phase_in;
   logic [trie_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [trie_pkg::ACC_W-1:0] outer_ff, outer_in, field_rem_ff, field_rem_in;
   logic [trie_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [trie_pkg::LB_W-1:0]  lbl_ff, lbl_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] fstart_ff, fstart_in;
   logic [1:0]  hsize_ff, hsize_in;
   logic        is_list_ff, is_list_in;
   logic        cap_ff, cap_in;
   logic [7:0]  first_byte_ff, first_byte_in;
   logic [1:0]  second_shape_ff, second_shape_in;
   logic        child_ok_ff, child_ok_in;
   logic        err_ff, err_in;
   logic        first_list_ff, first_list_in;
   logic [trie_pkg::ACC_W-1:0] first_size_ff, first_size_in;

   // Scratch for one byte.
   logic                        desc_fire;
   logic [trie_pkg::ACC_W-1:0]  d_content;
   logic [1:0]                  d_hdr;
   logic                        d_list;
   logic [1:0]                  d_shape;
   logic [trie_pkg::ACC_W-1:0]  acc_next;
   logic [trie_pkg::LB_W-1:0]   width;
   logic                        fin_hdr;
   logic [trie_pkg::ACC_W-1:0]  fin_content;
   logic                        ok;
   logic [1:0]                  kind;
   logic [6:0]                  nib;
   logic                        odd;
   logic [3:0]                  flag;
   logic [6:0]                  c7;

   always_comb begin
      phase_in        = phase_ff;
      outer_in        = outer_ff;
      field_rem_in    = field_rem_ff;
      acc_in          = acc_ff;
      lbl_in          = lbl_ff;
      count_in        = count_ff;
      fstart_in       = fstart_ff;
      hsize_in        = hsize_ff;
      is_list_in      = is_list_ff;
      cap_in          = cap_ff;
      first_byte_in   = first_byte_ff;
      second_shape_in = second_shape_ff;
      child_ok_in     = child_ok_ff;
      err_in          = err_ff;
      first_list_in   = first_list_ff;
      first_size_in   = first_size_ff;
      pos_in          = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
      desc_fire   = 1'b0;
      d_content   = '0;
      d_hdr       = hsize_ff;
      d_list      = is_list_ff;
      fin_hdr     = 1'b0;
      fin_content = '0;
      width       = '0;
      acc_next    = {acc_ff[trie_pkg::ACC_W-9:0], data_byte};

      if (!err_ff) begin
         unique case (phase_ff)
            trie_pkg::PH_OUTER_HDR: begin
               if (data_byte < 8'hc0) begin
                  err_in = 1'b1;
               end else if (data_byte <= 8'hf7) begin
                  outer_in = trie_pkg::ACC_W'(data_byte - 8'hc0);
                  phase_in = (data_byte == 8'hc0) ? trie_pkg::PH_DONE
                                                  : trie_pkg::PH_FIELD_HDR;
               end else if (32'(data_byte - 8'hf7) > trie_pkg::LEN_BYTES) begin
                  err_in = 1'b1;
               end else begin
                  lbl_in   = trie_pkg::LB_W'(data_byte - 8'hf7);
                  acc_in   = '0;
                  phase_in = trie_pkg::PH_OUTER_LEN;
               end
            end
            trie_pkg::PH_OUTER_LEN: begin
               if (acc_ff > LEN_LIMIT_HI) begin
                  err_in = 1'b1;
               end else begin
                  acc_in = acc_next;
                  lbl_in = lbl_ff - 1'b1;
                  if (lbl_ff == trie_pkg::LB_W'(1)) begin
                     outer_in = acc_next;
                     phase_in = (acc_next == '0) ? trie_pkg::PH_DONE
                                                 : trie_pkg::PH_FIELD_HDR;
                  end
               end
            end
            trie_pkg::PH_FIELD_HDR: begin
               if (count_ff >= trie_pkg::BRANCH_FIELDS) begin
                  err_in = 1'b1;
               end else begin
                  fstart_in  = pos_ff[15:0];
                  outer_in   = outer_ff - 1'b1;
                  is_list_in = (data_byte >= 8'hc0);
                  d_list     = (data_byte >= 8'hc0);
                  if (data_byte <= 8'h7f) begin
                     hsize_in  = 2'd0;
                     d_hdr     = 2'd0;
                     d_content = trie_pkg::ACC_W'(1);
                     desc_fire = 1'b1;
                     if (count_ff == 5'd0) begin
                        cap_in        = 1'b1;
                        first_byte_in = data_byte;
                     end
                     count_in = count_ff + 1'b1;
                     phase_in = (outer_ff == trie_pkg::ACC_W'(1)) ? trie_pkg::PH_DONE
                                                                  : trie_pkg::PH_FIELD_HDR;
                  end else if (data_byte <= 8'hb7 ||
                               (data_byte >= 8'hc0 && data_byte <= 8'hf7)) begin
                     hsize_in    = 2'd1;
                     d_hdr       = 2'd1;
                     fin_hdr     = 1'b1;
                     fin_content = trie_pkg::ACC_W'(data_byte <= 8'hb7 ? data_byte - 8'h80
                                                                       : data_byte - 8'hc0);
                  end else begin
                     width = trie_pkg::LB_W'(data_byte <= 8'hbf ? data_byte - 8'hb7
                                                                : data_byte - 8'hf7);
                     if (32'(width) > trie_pkg::LEN_BYTES ||
                         trie_pkg::ACC_W'(width) > outer_ff - 1'b1) begin
                        err_in = 1'b1;
                     end else begin
                        hsize_in = 2'(width + 1'b1);
                        lbl_in   = width;
                        acc_in   = '0;
                        phase_in = trie_pkg::PH_FIELD_LEN;
                     end
                  end
               end
            end
            trie_pkg::PH_FIELD_LEN: begin
               if (acc_ff > LEN_LIMIT_HI) begin
                  err_in = 1'b1;
               end else begin
                  acc_in   = acc_next;
                  lbl_in   = lbl_ff - 1'b1;
                  outer_in = outer_ff - 1'b1;
                  if (lbl_ff == trie_pkg::LB_W'(1)) begin
                     fin_hdr     = 1'b1;
                     fin_content = acc_next;
                  end
               end
            end
            trie_pkg::PH_FIELD_BODY: begin
               if (count_ff == 5'd0 && !cap_ff) begin
                  cap_in        = 1'b1;
                  first_byte_in = data_byte;
               end
               outer_in     = outer_ff - 1'b1;
               field_rem_in = field_rem_ff - 1'b1;
               if (field_rem_ff == trie_pkg::ACC_W'(1)) begin
                  count_in = count_ff + 1'b1;
                  phase_in = (outer_ff == trie_pkg::ACC_W'(1)) ? trie_pkg::PH_DONE
                                                               : trie_pkg::PH_FIELD_HDR;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase

         // Close a header: check against the outer list, then describe.
         if (fin_hdr) begin
            if (fin_content > outer_in) begin
               err_in = 1'b1;
            end else begin
               desc_fire    = 1'b1;
               d_content    = fin_content;
               field_rem_in = fin_content;
               if (fin_content == '0) begin
                  count_in = count_ff + 1'b1;
                  phase_in = (outer_in == '0) ? trie_pkg::PH_DONE : trie_pkg::PH_FIELD_HDR;
               end else begin
                  phase_in = trie_pkg::PH_FIELD_BODY;
               end
            end
         end
      end

      if (d_list)
         d_shape = (trie_pkg::ACC_W'(d_hdr) + d_content < trie_pkg::ACC_W'(32))
                   ? trie_pkg::SHAPE_INLINE : trie_pkg::SHAPE_OTHER;
      else if (d_hdr == 2'd0)
         d_shape = trie_pkg::SHAPE_OTHER;
      else if (d_content == '0)
         d_shape = trie_pkg::SHAPE_EMPTY;
      else if (d_content == trie_pkg::ACC_W'(32))
         d_shape = trie_pkg::SHAPE_HASH;
      else
         d_shape = trie_pkg::SHAPE_OTHER;

      if (desc_fire) begin
         if (count_ff == 5'd0) begin
            first_list_in = d_list;
            first_size_in = d_content;
         end
         if (count_ff == 5'd1)
            second_shape_in = d_shape;
         if (count_ff < 5'd16 && d_shape == trie_pkg::SHAPE_OTHER)
            child_ok_in = 1'b0;
      end

      // Verdict on the state after this byte.
      ok   = !err_in && phase_in == trie_pkg::PH_DONE;
      kind = trie_pkg::KIND_NONE;
      nib  = '0;
      odd  = 1'b0;
      flag = first_byte_in[7:4];
      c7   = first_size_in[6:0];
      if (ok && count_in == 5'd2) begin
         if (first_list_in || first_size_in == '0 ||
             first_size_in > trie_pkg::ACC_W'(33) || flag > 4'd3) begin
            ok = 1'b0;
         end else begin
            odd = flag[0];
            if (odd ? (c7 > 7'd32) : (first_byte_in[3:0] != 4'd0))
               ok = 1'b0;
            nib = odd ? 7'((c7 << 1) - 7'd1) : 7'((c7 << 1) - 7'd2);
            if (ok && flag[1])
               kind = trie_pkg::KIND_LEAF;
            else if (ok && nib != 7'd0 && second_shape_in != trie_pkg::SHAPE_OTHER)
               kind = trie_pkg::KIND_EXT;
            else
               ok = 1'b0;
         end
      end else if (ok && count_in == trie_pkg::BRANCH_FIELDS) begin
         ok   = child_ok_in;
         kind = trie_pkg::KIND_BRANCH;
      end else begin
         ok = 1'b0;
      end
      if (!ok || kind == trie_pkg::KIND_BRANCH) begin
         nib = '0;
         odd = 1'b0;
      end
      if (!ok)
         kind = trie_pkg::KIND_NONE;

      step = '0;
      step.desc_valid = desc_fire;
      step.verd_valid = end_of_node;
      step.desc.field_index   = count_ff;
      step.desc.field_is_list = d_list;
      step.desc.field_start   = desc_fire ? fstart_in : 16'd0;
      step.desc.header_size   = d_hdr;
      step.desc.content_size  = d_content[15:0];
      step.desc.child_shape   = d_shape;
      step.desc.last_result   = !end_of_node;
      step.verd.record_type   = 1'b1;
      step.verd.node_kind     = kind;
      step.verd.path_nibbles  = nib;
      step.verd.path_odd      = odd;
      step.verd.node_valid    = ok;
      step.verd.last_result   = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && end_of_node)) begin
         phase_ff        <= trie_pkg::PH_OUTER_HDR;
         pos_ff          <= '0;
         outer_ff        <= '0;
         field_rem_ff    <= '0;
         acc_ff          <= '0;
         lbl_ff          <= '0;
         count_ff        <= '0;
         fstart_ff       <= '0;
         hsize_ff        <= '0;
         is_list_ff      <= 1'b0;
         cap_ff          <= 1'b0;
         first_byte_ff   <= '0;
         second_shape_ff <= '0;
         child_ok_ff     <= 1'b1;
         err_ff          <= 1'b0;
         first_list_ff   <= 1'b0;
         first_size_ff   <= '0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         pos_ff          <= pos_in;
         outer_ff        <= outer_in;
         field_rem_ff    <= field_rem_in;
         acc_ff          <= acc_in;
         lbl_ff          <= lbl_in;
         count_ff        <= count_in;
         fstart_ff       <= fstart_in;
         hsize_ff        <= hsize_in;
         is_list_ff      <= is_list_in;
         cap_ff          <= cap_in;
         first_byte_ff   <= first_byte_in;
         second_shape_ff <= second_shape_in;
         child_ok_ff     <= child_ok_in;
         err_ff          <= err_in;
         first_list_ff   <= first_list_in;
         first_size_ff   <= first_size_in;
      end
   end

endmodule

FILE: hw/rtl/trie_out.sv
module trie_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  trie_pkg::step_type step,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output trie_pkg::rec_type  rec
);

   // Two-slot result holder: a byte's descriptor and verdict.
   trie_pkg::rec_type  slot_ff [2];
   trie_pkg::rec_type  slot_in [2];
   logic [1:0] vld_ff, vld_in;
   logic       pop;

   assign rsp_valid = vld_ff[0];
   assign rec       = slot_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign busy      = vld_ff[1] || (vld_ff[0] && !pop);

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      vld_in     = vld_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         vld_in     = {1'b0, vld_ff[1]};
      end
      if (load) begin
         if (step.desc_valid) begin
            slot_in[0] = step.desc;
            slot_in[1] = step.verd;
            vld_in     = {step.verd_valid, 1'b1};
         end else if (step.verd_valid) begin
            slot_in[0] = step.verd;
            vld_in     = 2'b01;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

endmodule

FILE: hw/rtl/trie_node_rlp_decoder.sv
// Streaming RLP decoder for one trie node, one byte per item. Each byte
// yields zero, one or two results: a field descriptor on the byte that
// completes a field header, and a verdict (leaf, extension, branch or
// invalid) on the byte marked end_of_node. A byte is taken in every cycle
// while the result holder is free; a byte that makes two results holds
// req_ready low while the first of them drains. The first result of a
// byte is registered and appears in the cycle after the byte is taken.
// The parser returns to its reset state after every verdict.
module trie_node_rlp_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_node,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_type,
   output logic [4:0]  rsp_field_index,
   output logic        rsp_field_is_list,
   output logic [15:0] rsp_field_start,
   output logic [1:0]  rsp_header_size,
   output logic [15:0] rsp_content_size,
   output logic [1:0]  rsp_child_shape,
   output logic [1:0]  rsp_node_kind,
   output logic [6:0]  rsp_path_nibbles,
   output logic        rsp_path_odd,
   output logic        rsp_node_valid,
   output logic        rsp_last_result
);

   trie_pkg::step_type step;
   trie_pkg::rec_type  rec;
   logic busy;
   logic accept;

   // Accept a byte whenever the result holder can take all its results.
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   trie_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step_en     (accept),
      .data_byte   (req_data_byte),
      .end_of_node (req_end_of_node),
      .step        (step)
   );

   trie_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .step      (step),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rec       (rec)
   );

   assign rsp_record_type   = rec.record_type;
   assign rsp_field_index   = rec.field_index;
   assign rsp_field_is_list = rec.field_is_list;
   assign rsp_field_start   = rec.field_start;
   assign rsp_header_size   = rec.header_size;
   assign rsp_content_size  = rec.content_size;
   assign rsp_child_shape   = rec.child_shape;
   assign rsp_node_kind     = rec.node_kind;
   assign rsp_path_nibbles  = rec.path_nibbles;
   assign rsp_path_odd      = rec.path_odd;
   assign rsp_node_valid    = rec.node_valid;
   assign rsp_last_result   = rec.last_result;

endmodule

FILE: hw/rtl/trie_checker.sv
`include "assert_macros.svh"

module trie_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_record_type,
   input logic [1:0] rsp_node_kind,
   input logic       rsp_node_valid,
   input logic       rsp_last_result
);

   // A verdict always ends the results of its byte.
   `CHK_IMPLY(a_verdict_last, clock, reset, rsp_valid && rsp_record_type, rsp_last_result)
   // An invalid verdict names no node kind.
   `CHK_IMPLY(a_invalid_kind, clock, reset,
              rsp_valid && rsp_record_type && !rsp_node_valid,
              rsp_node_kind == trie_pkg::KIND_NONE)
   // A pending result that is not last is followed by another result.
   `CHK_NEXT(a_pair, clock, reset, rsp_valid && rsp_ready && !rsp_last_result, rsp_valid)
   // Stalled result holds.
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // A byte refused by the block stays offered.
   `CHK_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid)

endmodule

bind trie_node_rlp_decoder trie_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_record_type (rsp_record_type),
   .rsp_node_kind   (rsp_node_kind),
   .rsp_node_valid  (rsp_node_valid),
   .rsp_last_result (rsp_last_result)
);
